// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    // default sizing of the block pool and of one map word
    localparam int MAX_BLOCKS_DEF    = 16384;
    localparam int MAP_WORD_BITS_DEF = 64;

    // field widths
    localparam int CMD_W     = 2;
    localparam int BLK_W     = 14;
    localparam int ST_W      = 2;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;

    // configuration reset values
    localparam logic [CFG_W-1:0] TOTAL_RST    = 15'd16384;
    localparam logic [CFG_W-1:0] RESERVED_RST = 15'd0;

    // commands
    typedef enum logic [CMD_W-1:0] {
        CMD_FORMAT = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2
    } t_cmd;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_NORES = 2'd1,
        ST_INVAL = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL    = 1'b0,
        CFG_RESERVED = 1'b1
    } t_cfg_idx;

    // per-word outcome flags from the word unit
    typedef struct packed {
        logic alloc_hit;
        logic free_ok;
    } t_word_flags;

endpackage

// ===== design/bba_map_ram.sv =====
// ----------------------------------------------------------------------------
// bba_map_ram
// used/free map storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module bba_map_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bba_word_alu.sv =====
// ----------------------------------------------------------------------------
// bba_word_alu
// shared per-word unit: range masks, first-free search, set and clear of bits
// ----------------------------------------------------------------------------
module bba_word_alu #(
    parameter int WB = 64,
    parameter int PW = 17
) (
    input  bba_pkg::t_cmd        i_cmd,
    input  logic [WB-1:0]        i_word,
    input  logic [PW-1:0]        i_base,
    input  logic [PW-1:0]        i_total,
    input  logic [PW-1:0]        i_resv,
    input  logic [PW-1:0]        i_blk,
    input  logic                 i_found,
    output logic [WB-1:0]        o_word,
    output logic [WB-1:0]        o_free_bits,
    output logic [PW-1:0]        o_grant,
    output bba_pkg::t_word_flags o_flags
);
    import bba_pkg::*;

    localparam int BW = $clog2(WB);

    logic signed [PW:0] rem_tot;
    logic signed [PW:0] rem_res;
    logic signed [PW:0] rem_blk;
    logic [WB-1:0]      tot_mask;
    logic [WB-1:0]      res_mask;
    logic [WB-1:0]      blk_onehot;
    logic [WB-1:0]      avail;
    logic [WB-1:0]      lowest;
    logic [BW-1:0]      low_idx;
    logic               blk_in_word;
    logic               blk_used;

    // positions relative to the first bit of this word
    always_comb begin
        rem_tot = $signed({1'b0, i_total}) - $signed({1'b0, i_base});
        rem_res = $signed({1'b0, i_resv})  - $signed({1'b0, i_base});
        rem_blk = $signed({1'b0, i_blk})   - $signed({1'b0, i_base});
        blk_in_word = (rem_blk >= 0) && (rem_blk < $signed((PW+1)'(WB)));
        for (int b = 0; b < WB; b++) begin
            tot_mask[b]   = rem_tot > $signed((PW+1)'(b));
            res_mask[b]   = rem_res > $signed((PW+1)'(b));
            blk_onehot[b] = blk_in_word && (rem_blk == $signed((PW+1)'(b)));
        end
    end

    // lowest free bit below the total
    always_comb begin
        avail   = ~i_word & tot_mask;
        lowest  = avail & (~avail + {{(WB-1){1'b0}}, 1'b1});
        low_idx = '0;
        for (int b = 0; b < WB; b++) begin
            if (lowest[b]) begin
                low_idx = low_idx | BW'(b);
            end
        end
        blk_used = |(blk_onehot & i_word & tot_mask);
        o_grant  = i_base + PW'(low_idx);
    end

    // word update per command
    always_comb begin
        o_word  = i_word;
        o_flags = '0;
        case (i_cmd)
            CMD_FORMAT: begin
                o_word = res_mask;
            end
            CMD_ALLOC: begin
                if (!i_found && (|avail)) begin
                    o_word            = i_word | lowest;
                    o_flags.alloc_hit = 1'b1;
                end
            end
            CMD_FREE: begin
                if (blk_used) begin
                    o_word          = i_word & ~blk_onehot;
                    o_flags.free_ok = 1'b1;
                end
            end
            default: begin
                o_word = i_word;
            end
        endcase
        o_free_bits = ~o_word & tot_mask;
    end

endmodule

// ===== design/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit block allocator over a used/free bitmap held in an on-chip memory
// ----------------------------------------------------------------------------
// usage
//   config port: i_cfg_we writes i_cfg_data into the managed block count
//   (index 0) or the reserved count (index 1); write only while no command
//   is in flight
//   input channel: i_command / i_block_number with i_in_valid / o_in_ready
//   output channel: o_status, o_allocated_block, o_free_count with
//   o_out_valid / i_out_ready
//   every command (format, allocate, free) is one sweep over all map words,
//   one word per cycle through the shared word unit, with the free count
//   accumulated on the way; each word passes the read, modify and count
//   stages; o_in_ready returns with the result, so a new command is only
//   accepted once the previous one has finished its sweep
//   reset: the map is filled with all ones (every block used) by a pass
//   over all map words, during which o_in_ready stays low
//   stall: the result sits in an output register; the next command is
//   accepted meanwhile, and its result waits until the register is taken
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS    = bba_pkg::MAX_BLOCKS_DEF,
    parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bba_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bba_pkg::CMD_W-1:0]     i_command,
    input  logic [bba_pkg::BLK_W-1:0]     i_block_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bba_pkg::ST_W-1:0]      o_status,
    output logic [bba_pkg::BLK_W-1:0]     o_allocated_block,
    output logic [bba_pkg::CFG_W-1:0]     o_free_count
);
    import bba_pkg::*;

    localparam int WB        = MAP_WORD_BITS;
    localparam int MAP_WORDS = (MAX_BLOCKS + WB - 1) / WB;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PW        = $clog2(MAP_WORDS * WB + (1 << CFG_W)) + 1;
    localparam int CNT_W     = $clog2(WB + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
    localparam logic [PW-1:0] MAX_EXT   = PW'(MAX_BLOCKS);
    localparam logic [PW-1:0] WB_EXT    = PW'(WB);

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    // control state
    t_state          r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_issue, n_issue;
    logic            r_s1_vld, n_s1_vld;
    logic            r_s2_vld, n_s2_vld;
    logic            r_out_valid, n_out_valid;
    logic [CFG_W-1:0] r_total, n_total;
    logic [CFG_W-1:0] r_resv, n_resv;

    // payload state
    logic [PW-1:0]    r_base, n_base;
    logic [AW-1:0]    r_s1_addr, n_s1_addr;
    logic [PW-1:0]    r_s1_base, n_s1_base;
    logic             r_s1_last, n_s1_last;
    logic             r_s2_last, n_s2_last;
    logic [WB-1:0]    r_s2_free, n_s2_free;
    t_cmd             r_cmd, n_cmd;
    logic [PW-1:0]    r_blk, n_blk;
    logic [PW-1:0]    r_tot, n_tot;
    logic [PW-1:0]    r_res, n_res;
    logic             r_found, n_found;
    logic [PW-1:0]    r_grant, n_grant;
    t_status          r_status, n_status;
    logic [CFG_W-1:0] r_acc, n_acc;
    t_status          r_o_status, n_o_status;
    logic [BLK_W-1:0] r_o_grant, n_o_grant;
    logic [CFG_W-1:0] r_o_free, n_o_free;

    // datapath wires
    logic [PW-1:0]    tot_ext, resv_ext, eff_total, eff_resv;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [WB-1:0]    ram_wdata, ram_rdata;
    logic [WB-1:0]    alu_word, alu_free;
    logic [PW-1:0]    alu_grant;
    t_word_flags      alu_flags;
    logic [CNT_W-1:0] pop;

    // effective total and reserved counts, saturated
    always_comb begin
        tot_ext   = {{(PW-CFG_W){1'b0}}, r_total};
        resv_ext  = {{(PW-CFG_W){1'b0}}, r_resv};
        eff_total = (tot_ext > MAX_EXT) ? MAX_EXT : tot_ext;
        eff_resv  = (resv_ext > eff_total) ? eff_total : resv_ext;
    end

    // map memory
    bba_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WB),
        .AW    (AW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // shared word unit
    bba_word_alu #(
        .WB (WB),
        .PW (PW)
    ) u_word_alu (
        .i_cmd       (r_cmd),
        .i_word      (ram_rdata),
        .i_base      (r_s1_base),
        .i_total     (r_tot),
        .i_resv      (r_res),
        .i_blk       (r_blk),
        .i_found     (r_found),
        .o_word      (alu_word),
        .o_free_bits (alu_free),
        .o_grant     (alu_grant),
        .o_flags     (alu_flags)
    );

    // memory port selection: fill pass after reset, else write-back of the sweep
    always_comb begin
        if (r_state == S_INIT) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = '1;
        end else begin
            ram_we    = r_s1_vld;
            ram_waddr = r_s1_addr;
            ram_wdata = alu_word;
        end
        ram_re = r_issue;
        pop    = CNT_W'($countones(r_s2_free));
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_issue     = r_issue;
        n_s1_vld    = 1'b0;
        n_s2_vld    = 1'b0;
        n_out_valid = r_out_valid;
        n_total     = r_total;
        n_resv      = r_resv;
        n_base      = r_base;
        n_s1_addr   = r_s1_addr;
        n_s1_base   = r_s1_base;
        n_s1_last   = r_s1_last;
        n_s2_last   = r_s2_last;
        n_s2_free   = r_s2_free;
        n_cmd       = r_cmd;
        n_blk       = r_blk;
        n_tot       = r_tot;
        n_res       = r_res;
        n_found     = r_found;
        n_grant     = r_grant;
        n_status    = r_status;
        n_acc       = r_acc;
        n_o_status  = r_o_status;
        n_o_grant   = r_o_grant;
        n_o_free    = r_o_free;

        // configuration writes
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TOTAL:    n_total = i_cfg_data;
                CFG_RESERVED: n_resv  = i_cfg_data;
                default:      n_total = r_total;
            endcase
        end

        // output register drains on a taken transaction
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = t_cmd'(i_command);
                    n_blk   = {{(PW-BLK_W){1'b0}}, i_block_number};
                    n_tot   = eff_total;
                    n_res   = eff_resv;
                    n_addr  = '0;
                    n_base  = '0;
                    n_issue = 1'b1;
                    n_found = 1'b0;
                    n_grant = '0;
                    n_acc   = '0;
                    case (t_cmd'(i_command))
                        CMD_FORMAT: n_status = ST_OK;
                        CMD_ALLOC:  n_status = ST_NORES;
                        default:    n_status = ST_INVAL;
                    endcase
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // issue reads, one word a cycle
                if (r_issue) begin
                    n_s1_vld  = 1'b1;
                    n_s1_addr = r_addr;
                    n_s1_base = r_base;
                    n_s1_last = (r_addr == LAST_ADDR);
                    if (r_addr == LAST_ADDR) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                        n_base = r_base + WB_EXT;
                    end
                end
                // modify and write back the word
                if (r_s1_vld) begin
                    n_s2_vld  = 1'b1;
                    n_s2_free = alu_free;
                    n_s2_last = r_s1_last;
                    if (alu_flags.alloc_hit) begin
                        n_found  = 1'b1;
                        n_grant  = alu_grant;
                        n_status = ST_OK;
                    end
                    if (alu_flags.free_ok) begin
                        n_status = ST_OK;
                    end
                end
                // count free bits below the total
                if (r_s2_vld) begin
                    n_acc = r_acc + CFG_W'(pop);
                    if (r_s2_last) begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_grant   = r_grant[BLK_W-1:0];
                    n_o_free    = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= TOTAL_RST;
            r_resv      <= RESERVED_RST;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_s1_vld    <= n_s1_vld;
            r_s2_vld    <= n_s2_vld;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
            r_resv      <= n_resv;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_s1_addr  <= n_s1_addr;
        r_s1_base  <= n_s1_base;
        r_s1_last  <= n_s1_last;
        r_s2_last  <= n_s2_last;
        r_s2_free  <= n_s2_free;
        r_cmd      <= n_cmd;
        r_blk      <= n_blk;
        r_tot      <= n_tot;
        r_res      <= n_res;
        r_found    <= n_found;
        r_grant    <= n_grant;
        r_status   <= n_status;
        r_acc      <= n_acc;
        r_o_status <= n_o_status;
        r_o_grant  <= n_o_grant;
        r_o_free   <= n_o_free;
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_allocated_block = r_o_grant;
    assign o_free_count      = r_o_free;

endmodule

// ===== design/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks of the bitmap block allocator, bound to the top level
// ----------------------------------------------------------------------------
module bba_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [bba_pkg::ST_W-1:0]  o_status,
    input logic [bba_pkg::BLK_W-1:0] o_allocated_block,
    input logic [bba_pkg::CFG_W-1:0] o_free_count
);
    import bba_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_allocated_block) && $stable(o_free_count))
        else $error("result changed while stalled");

    // only a successful transaction carries a block number
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_allocated_block == '0)
        else $error("block number on a failed command");

    // one command at a time: busy right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

    // reset empties the output and starts the map fill pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("active after reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_allocated_block (o_allocated_block),
    .o_free_count      (o_free_count)
);

// ===== verif/tb_bitmap_block_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator
// self-checking testbench: format, allocate and free commands against a
// bitmap scoreboard, with random idling on both channels and config changes
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;
    import bba_pkg::*;

    localparam int POOL_BLOCKS    = MAX_BLOCKS_DEF;
    localparam int WORD_BITS      = MAP_WORD_BITS_DEF;
    localparam int MAP_WORDS      = (POOL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 101;

    // the command code the package leaves unnamed; the block leaves the map unchanged and answers it as invalid
    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    typedef struct packed {
        t_status          status;
        logic [BLK_W-1:0] block;
        logic [CFG_W-1:0] free_count;
    } t_alloc_reply;

    // bitmap scoreboard: mirrors the used map and queues the awaited replies
    class bitmap_scoreboard;
        bit [WORD_BITS-1:0] used_map [MAP_WORDS];
        logic [CFG_W-1:0]   total_reg;
        logic [CFG_W-1:0]   reserved_reg;
        t_alloc_reply       awaited_replies [$];
        int unsigned        errors;

        function new();
            foreach (used_map[i]) used_map[i] = '1;
            total_reg    = TOTAL_RST;
            reserved_reg = RESERVED_RST;
            errors       = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            if (idx == CFG_TOTAL) total_reg = data;
            else reserved_reg = data;
        endfunction

        function int unsigned effective_total();
            return (total_reg > POOL_BLOCKS) ? POOL_BLOCKS : int'(total_reg);
        endfunction

        // clear bits below the limit
        function int unsigned count_free(int unsigned lim);
            int unsigned n;
            int unsigned base;
            n = 0;
            for (int w = 0; w < MAP_WORDS; w++) begin
                base = w * WORD_BITS;
                if (base >= lim) break;
                if (base + WORD_BITS <= lim) begin
                    n += WORD_BITS - $countones(used_map[w]);
                end else begin
                    for (int b = 0; b < int'(lim - base); b++)
                        if (!used_map[w][b]) n++;
                end
            end
            return n;
        endfunction

        // work out the reply of one accepted command and update the map
        function void note_command(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] blk);
            t_alloc_reply r;
            int unsigned  lim;
            int unsigned  res;
            int unsigned  b;
            lim     = effective_total();
            r.status = ST_OK;
            r.block  = '0;
            case (cmd)
                CMD_FORMAT: begin
                    res = (reserved_reg > lim) ? lim : int'(reserved_reg);
                    foreach (used_map[i]) used_map[i] = '0;
                    for (int i = 0; i < int'(res); i++)
                        used_map[i / WORD_BITS][i % WORD_BITS] = 1'b1;
                end
                CMD_ALLOC: begin
                    r.status = ST_NORES;
                    for (int w = 0; w < MAP_WORDS; w++) begin
                        if (w * WORD_BITS >= lim) break;
                        if (used_map[w] != '1) begin
                            // lowest clear bit of this word decides
                            b = 0;
                            while (used_map[w][b]) b++;
                            if (w * WORD_BITS + b < lim) begin
                                used_map[w][b] = 1'b1;
                                r.status = ST_OK;
                                r.block  = BLK_W'(w * WORD_BITS + b);
                            end
                            break;
                        end
                    end
                end
                CMD_FREE: begin
                    if (blk >= lim || !used_map[blk / WORD_BITS][blk % WORD_BITS])
                        r.status = ST_INVAL;
                    else
                        used_map[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
                end
                default: r.status = ST_INVAL;
            endcase
            r.free_count = CFG_W'(count_free(lim));
            awaited_replies.push_back(r);
        endfunction

        function void check_reply(logic [ST_W-1:0] st, logic [BLK_W-1:0] blk,
                                  logic [CFG_W-1:0] cnt);
            t_alloc_reply r;
            if (awaited_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply: status %0d block %0d free %0d",
                         $time, st, blk, cnt);
                return;
            end
            r = awaited_replies.pop_front();
            if (st !== r.status || blk !== r.block || cnt !== r.free_count) begin
                errors++;
                $display("%0t: reply mismatch: status exp %0d got %0d",
                         $time, r.status, st);
                $display("%0t:   block exp %0d got %0d", $time, r.block, blk);
                $display("%0t:   free count exp %0d got %0d",
                         $time, r.free_count, cnt);
            end
        endfunction

        function int unsigned outstanding();
            return awaited_replies.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [CMD_W-1:0]   i_command;
    logic [BLK_W-1:0]   i_block_number;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [ST_W-1:0]    o_status;
    logic [BLK_W-1:0]   o_allocated_block;
    logic [CFG_W-1:0]   o_free_count;

    bitmap_scoreboard   sb = new();
    bit                 send_quiet;
    bit                 recv_quiet;
    int unsigned        stall_cycles;

    bitmap_block_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_block_number   (i_block_number),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_allocated_block(o_allocated_block),
        .o_free_count     (o_free_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gap length: mostly none, some short, a few long
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 600);
    endfunction

    // one command transaction; valid stays up back to back when there is no gap
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] blk);
        int unsigned gap;
        gap = pick_gap(send_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_block_number <= blk;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(cmd, blk);
    endtask

    // stop sending and wait for every awaited reply
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_W-1:0] total, logic [CFG_W-1:0] reserved);
        wait_drained();
        write_register(CFG_TOTAL, total);
        write_register(CFG_RESERVED, reserved);
    endtask

    // random phase: mostly format followed by allocs and frees near the fill line
    task automatic run_phase(logic [CFG_W-1:0] total, logic [CFG_W-1:0] reserved,
                             bit do_format, bit hold_mid);
        int unsigned lim;
        int unsigned resv;
        int unsigned allocs;
        int unsigned hi;
        int unsigned r;
        set_config(total, reserved);
        lim        = (total > POOL_BLOCKS) ? POOL_BLOCKS : int'(total);
        resv       = (reserved > lim) ? lim : int'(reserved);
        allocs     = 0;
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
        if (do_format) send_command(CMD_FORMAT, BLK_W'($urandom));
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (hold_mid && k == PHASE_ITEMS / 2) wait_drained();
            r  = $urandom_range(0, 99);
            hi = resv + allocs + 3;
            if (hi > lim + 3) hi = lim + 3;
            if (hi > POOL_BLOCKS - 1) hi = POOL_BLOCKS - 1;
            if (r < 45) begin
                send_command(CMD_ALLOC, BLK_W'($urandom));
                allocs++;
            end else if (r < 83) begin
                send_command(CMD_FREE, BLK_W'($urandom_range(0, hi)));
            end else if (r < 93) begin
                send_command(CMD_FREE, BLK_W'($urandom));
            end else if (r < 97) begin
                send_command(CMD_FORMAT, BLK_W'($urandom));
                allocs = 0;
            end else begin
                send_command(CMD_RSVD, BLK_W'($urandom));
            end
        end
    endtask

    // result side: random stalls between reply transactions
    initial begin
        int unsigned gap;
        i_out_ready = 1'b0;
        forever begin
            gap = pick_gap(recv_quiet);
            repeat (gap) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // reply monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_reply(o_status, o_allocated_block, o_free_count);
    end

    // cycles without any transaction or config write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog expired", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial begin
        bit          fmt;
        logic [CFG_W-1:0] tot;
        logic [CFG_W-1:0] rsv;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_TOTAL;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_command      = CMD_FORMAT;
        i_block_number = '0;
        send_quiet     = 1'b0;
        recv_quiet     = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: map all used after reset, default totals
        send_command(CMD_ALLOC, '0);
        send_command(CMD_FREE, '0);
        send_command(CMD_FREE, '1);
        send_command(CMD_FREE, '1);          // already free
        send_command(CMD_RSVD, '1);          // no-op command
        send_command(CMD_ALLOC, '1);
        send_command(CMD_FORMAT, '0);
        send_command(CMD_ALLOC, '0);
        send_command(CMD_ALLOC, '0);
        send_command(CMD_FREE, 14'd1);
        send_command(CMD_FREE, 14'd1);
        // total of zero
        set_config(15'd0, 15'd0);
        send_command(CMD_ALLOC, '0);
        send_command(CMD_FREE, '0);
        send_command(CMD_FORMAT, '0);
        // total above the pool, reserved saturating
        set_config('1, '1);
        send_command(CMD_FORMAT, '1);
        send_command(CMD_ALLOC, '0);
        send_command(CMD_FREE, '1);
        send_command(CMD_ALLOC, '0);
        // single block
        set_config(15'd1, 15'd0);
        send_command(CMD_FORMAT, '0);
        send_command(CMD_ALLOC, '0);
        send_command(CMD_ALLOC, '0);
        send_command(CMD_FREE, '0);
        // total raised after format
        set_config(15'd100, 15'd5);
        send_command(CMD_FORMAT, '0);
        wait_drained();
        write_register(CFG_TOTAL, 15'd200);
        send_command(CMD_ALLOC, '0);
        send_command(CMD_FREE, 14'd150);

        // random phases, extremes first
        for (int p = 0; p < PHASES; p++) begin
            fmt = (p == 0) || ($urandom_range(0, 4) != 0);
            case (p)
                0: begin tot = 15'd16384; rsv = 15'd0; end
                1: begin tot = 15'd1;     rsv = 15'd0; end
                2: begin tot = '1;        rsv = CFG_W'($urandom_range(0, 200)); end
                3: begin tot = 15'd0;     rsv = CFG_W'($urandom_range(0, 10)); end
                4: begin tot = 15'd64;    rsv = 15'd64; end
                5: begin tot = 15'd65;    rsv = '1; end
                default: begin
                    if ($urandom_range(0, 9) < 7) begin
                        tot = CFG_W'($urandom_range(1, 300));
                        rsv = CFG_W'($urandom_range(0, tot / 2));
                    end else begin
                        tot = CFG_W'($urandom);
                        rsv = CFG_W'($urandom);
                    end
                end
            endcase
            run_phase(tot, rsv, fmt, p == 6);
        end

        // drain, then let any stray reply show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
